// ===== hw/rtl/event_trace_ring_buffer_unit_defines.svh =====
// assertion macros for the event trace ring buffer unit
`ifndef EVENT_TRACE_RING_BUFFER_UNIT_DEFINES_SVH
`define EVENT_TRACE_RING_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ETRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ETRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/etrb_pkg.sv =====
// shared types and constants of the event trace ring buffer
`default_nettype none

package etrb_pkg;

    // log geometry
    localparam int LOG_DEPTH = 256;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    // field widths
    localparam int REQ_W   = 2;
    localparam int IFACE_W = 8;
    localparam int STAMP_W = 64;
    localparam int RIDX_W  = 8;
    localparam int LIDX_W  = 8;
    localparam int SIZE_W  = 9;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ACTIVATE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEACTIVATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ       = 2'd3;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } ctrl_state_t;

    // one stored log entry
    typedef struct packed {
        logic               kind;
        logic [IFACE_W-1:0] iface;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // one result item
    typedef struct packed {
        logic               accepted;
        logic [LIDX_W-1:0]  latest_index;
        logic [SIZE_W-1:0]  log_size;
        logic               read_valid;
        logic [IFACE_W-1:0] read_iface;
        logic               read_kind;
        logic [STAMP_W-1:0] read_timestamp;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic do_write;
        logic do_clear;
        logic do_read;
        logic load_now;
        logic load_ok;
        logic load_read;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic logging_enabled;
        logic skid_full;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/etrb_if.sv =====
// request and result channel interfaces
`default_nettype none

interface etrb_req_if
    import etrb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [IFACE_W-1:0] event_iface;
    logic [STAMP_W-1:0] event_time;
    logic [RIDX_W-1:0]  read_index;

    modport source (output valid, output req_type, output event_iface,
                    output event_time, output read_index, input ready);
    modport sink   (input valid, input req_type, input event_iface,
                    input event_time, input read_index, output ready);
endinterface

interface etrb_rsp_if
    import etrb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [LIDX_W-1:0]  latest_index;
    logic [SIZE_W-1:0]  log_size;
    logic               read_valid;
    logic [IFACE_W-1:0] read_iface;
    logic               read_kind;
    logic [STAMP_W-1:0] read_timestamp;

    modport source (output valid, output accepted, output latest_index, output log_size,
                    output read_valid, output read_iface, output read_kind,
                    output read_timestamp, input ready);
    modport sink   (input valid, input accepted, input latest_index, input log_size,
                    input read_valid, input read_iface, input read_kind,
                    input read_timestamp, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/event_trace_ring_buffer_unit.sv =====
// Event trace ring buffer unit: 256-entry circular log of interface events.
// Log and clear results load into the output register, or the skid stage while
// the output is held; a read result loads the same way from the registered read of
// the log memory port. One log or clear request is taken per cycle while the skid
// stage is empty, none while a read is pending. Reset clears the write position,
// fill count, logging enable and result valid flags; not log memory or result data.
`default_nettype none

`include "event_trace_ring_buffer_unit_defines.svh"

module event_trace_ring_buffer_unit
    import etrb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_wr_en,
    input  wire logic  cfg_wr_data,
    etrb_req_if.sink   request,
    etrb_rsp_if.source result
);

    cmd_t  cmd;
    stat_t stat;
    logic  ctrl_ready;

    // controller
    etrb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (request.valid),
        .in_req_type (request.req_type),
        .stat        (stat),
        .in_ready    (ctrl_ready),
        .cmd         (cmd)
    );

    assign request.ready = ctrl_ready;

    // datapath
    etrb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .in_req_type    (request.req_type),
        .in_event_iface (request.event_iface),
        .in_event_time  (request.event_time),
        .in_read_index  (request.read_index),
        .stat           (stat),
        .rsp            (result)
    );

    // checks on the read sequence and result staging
    `ETRB_ASSERT_NEXT(a_read_loads_next, clk, rst_n, cmd.do_read, cmd.load_read,
        "read request did not load its result in the next cycle")
    `ETRB_ASSERT_NOW(a_read_skid_free, clk, rst_n, cmd.load_read, !stat.skid_full,
        "read result loaded while the skid stage is full")
    `ETRB_ASSERT_NOW(a_size_bound, clk, rst_n, result.valid,
        result.log_size <= SIZE_W'(LOG_DEPTH),
        "reported log size above the log depth")

endmodule

`default_nettype wire

// ===== hw/rtl/etrb_ctrl.sv =====
// request controller: acceptance, command decode and read sequencing
`default_nettype none

module etrb_ctrl
    import etrb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [REQ_W-1:0] in_req_type,
    input  wire stat_t            stat,
    output logic                  in_ready,
    output cmd_t                  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;
    logic        is_log;

    // request decode
    assign is_log = in_req_type inside {REQ_ACTIVATE, REQ_DEACTIVATE};
    assign accept = in_ready && in_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_req_type == REQ_READ))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = !stat.skid_full;
                cmd.do_write = accept && is_log && stat.logging_enabled;
                cmd.do_clear = accept && (in_req_type == REQ_CLEAR);
                cmd.do_read  = accept && (in_req_type == REQ_READ);
                cmd.load_now = accept && (in_req_type != REQ_READ);
                cmd.load_ok  = (is_log && stat.logging_enabled) || (in_req_type == REQ_CLEAR);
            end
            ST_READ:
            begin
                cmd.load_read = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/etrb_datapath.sv =====
// datapath: log memory, write position, fill count and result registers
`default_nettype none

module etrb_datapath
    import etrb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire cmd_t               cmd,
    input  wire logic [REQ_W-1:0]   in_req_type,
    input  wire logic [IFACE_W-1:0] in_event_iface,
    input  wire logic [STAMP_W-1:0] in_event_time,
    input  wire logic [RIDX_W-1:0]  in_read_index,
    output stat_t                   stat,
    etrb_rsp_if.source              rsp
);

    // log storage, contents undefined until written
    entry_t mem [LOG_DEPTH];

    logic             logging_enabled_reg;
    logic [IDX_W-1:0] write_index_reg;
    logic [IDX_W-1:0] write_index_next;
    logic [CNT_W-1:0] filled_reg;
    logic [CNT_W-1:0] filled_next;
    entry_t           rd_data_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_hit;
    entry_t           wr_entry;
    logic [IDX_W-1:0] latest_slot;
    result_t          new_res;
    logic             load;
    logic             drain;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             skid_valid_reg;
    result_t          skid_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logging_enabled_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            logging_enabled_reg <= cfg_wr_data;
        end
    end

    // write position and fill count update
    always_comb
    begin
        write_index_next = write_index_reg;
        filled_next      = filled_reg;
        if (cmd.do_clear)
        begin
            write_index_next = '0;
            filled_next      = '0;
        end
        else if (cmd.do_write)
        begin
            if (write_index_reg == IDX_W'(LOG_DEPTH - 1))
            begin
                write_index_next = '0;
            end
            else
            begin
                write_index_next = write_index_reg + 1'b1;
            end
            if (filled_reg < CNT_W'(LOG_DEPTH))
            begin
                filled_next = filled_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            filled_reg      <= '0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            filled_reg      <= filled_next;
        end
    end

    // memory write and registered read
    assign wr_entry.kind  = in_req_type[0];
    assign wr_entry.iface = in_event_iface;
    assign wr_entry.stamp = in_event_time;
    assign rd_addr        = IDX_W'(in_read_index);
    assign rd_hit         = CNT_W'(in_read_index) < filled_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
        begin
            mem[write_index_reg] <= wr_entry;
        end
        if (cmd.do_read)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= rd_hit;
        end
    end

    // latest slot after the request takes effect
    always_comb
    begin
        if (filled_next == '0)
        begin
            latest_slot = '0;
        end
        else if (write_index_next == '0)
        begin
            latest_slot = IDX_W'(LOG_DEPTH - 1);
        end
        else
        begin
            latest_slot = write_index_next - 1'b1;
        end
    end

    // result assembly
    always_comb
    begin
        new_res              = '0;
        new_res.latest_index = LIDX_W'(latest_slot);
        new_res.log_size     = SIZE_W'(filled_next);
        if (cmd.load_read)
        begin
            new_res.accepted   = 1'b1;
            new_res.read_valid = rd_valid_reg;
            if (rd_valid_reg)
            begin
                new_res.read_iface     = rd_data_reg.iface;
                new_res.read_kind      = rd_data_reg.kind;
                new_res.read_timestamp = rd_data_reg.stamp;
            end
        end
        else
        begin
            new_res.accepted = cmd.load_ok;
        end
    end

    assign load  = cmd.load_now || cmd.load_read;
    assign drain = out_valid_reg && rsp.ready;

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                if (!out_valid_reg || drain)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (drain)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (!out_valid_reg || drain)
            begin
                out_reg <= new_res;
            end
            else
            begin
                skid_reg <= new_res;
            end
        end
        else if (drain && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    // status and result channel
    assign stat.logging_enabled = logging_enabled_reg;
    assign stat.skid_full       = skid_valid_reg;

    assign rsp.valid          = out_valid_reg;
    assign rsp.accepted       = out_reg.accepted;
    assign rsp.latest_index   = out_reg.latest_index;
    assign rsp.log_size       = out_reg.log_size;
    assign rsp.read_valid     = out_reg.read_valid;
    assign rsp.read_iface     = out_reg.read_iface;
    assign rsp.read_kind      = out_reg.read_kind;
    assign rsp.read_timestamp = out_reg.read_timestamp;

endmodule

`default_nettype wire
